@@ rtl/wfmc_pkg.sv @@
// Types, constants and codes shared by the wall-follow motion controller.
`timescale 1ns / 1ps
package wfmc_pkg;

  typedef enum logic [2:0] {
    PH_FORWARD = 3'd0,
    PH_CREEP   = 3'd1,
    PH_LEFT    = 3'd2,
    PH_RIGHT   = 3'd3,
    PH_DECIDE  = 3'd4,
    PH_PAUSE   = 3'd5,
    PH_BACK    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    REG_BASE_SPEED      = 3'd0,
    REG_CENTER_STOP     = 3'd1,
    REG_LEFT_WALL       = 3'd2,
    REG_RIGHT_WALL      = 3'd3,
    REG_LEFT_OPEN       = 3'd4,
    REG_RIGHT_OPEN      = 3'd5,
    REG_TURN_TICKS      = 3'd6,
    REG_BACK_TIMEOUT    = 3'd7
  } reg_idx_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [8:0]  BOOST     = 9'd55;
  localparam logic [8:0]  DUTY_MIN  = 9'd120;
  localparam logic [8:0]  DUTY_MAX  = 9'd255;
  localparam logic [7:0]  TURN_DUTY = 8'd170;
  localparam logic [7:0]  BACK_DUTY = 8'd160;
  localparam logic [15:0] CREEP_MS  = 16'd300;
  localparam logic [15:0] PAUSE_MS  = 16'd200;

  typedef struct packed {
    logic [7:0]  base_speed;
    logic [15:0] front_block_dist;
    logic [15:0] left_near_dist;
    logic [15:0] right_near_dist;
    logic [15:0] left_open_threshold;
    logic [15:0] right_open_threshold;
    logic [15:0] turn_tick_target;
    logic [15:0] backward_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [15:0]       dist_right;
    logic [15:0]       dist_center;
    logic [15:0]       dist_left;
    logic signed [7:0] enc_left_delta;
    logic signed [7:0] enc_right_delta;
    logic [7:0]        elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pwm_a;
    logic [7:0] pwm_b;
    logic       a_in1_high;
    logic       b_in1_high;
    logic [2:0] phase_code;
  } out_item_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] phase_timer;
    logic [15:0] turn_sum;
    logic        return_to_decide;
    logic        pending_right_turn;
    logic        dir_a;
    logic        dir_b;
  } state_t;

  function automatic logic [7:0] abs8(input logic [7:0] v);
    abs8 = v[7] ? 8'(9'h100 - {1'b0, v}) : v;
  endfunction

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add16 = s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

@@ rtl/wfmc_in_if.sv @@
// Input channel carrying one control-period sample.
`timescale 1ns / 1ps
interface wfmc_in_if import wfmc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/wfmc_out_if.sv @@
// Result channel carrying motor drive and phase.
`timescale 1ns / 1ps
interface wfmc_out_if import wfmc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/wfmc_step.sv @@
// Next-state and drive logic for one control period.
`timescale 1ns / 1ps
module wfmc_step import wfmc_pkg::*; (
  input  cfg_t      cfg,
  input  state_t    st,
  input  in_item_t  item,
  output state_t    st_nxt,
  output out_item_t res
);

  logic        left_open;
  logic        right_open;
  logic [8:0]  ticks;
  logic [15:0] timer_sat;
  logic [15:0] turn_sat;
  logic [8:0]  sum_a;
  logic [8:0]  sum_b;
  logic [7:0]  da;
  logic [7:0]  db;

  assign left_open  = item.dist_left > cfg.left_open_threshold;
  assign right_open = item.dist_right > cfg.right_open_threshold;
  assign ticks      = {1'b0, abs8(item.enc_left_delta)} + {1'b0, abs8(item.enc_right_delta)};
  assign timer_sat  = sat_add16(st.phase_timer, {8'd0, item.elapsed_ms});
  assign turn_sat   = sat_add16(st.turn_sum, {7'd0, ticks});
  assign sum_a = {1'b0, cfg.base_speed} +
                 ((item.dist_right < cfg.right_near_dist) ? BOOST : 9'd0);
  assign sum_b = {1'b0, cfg.base_speed} +
                 ((item.dist_left < cfg.left_near_dist) ? BOOST : 9'd0);

  always_comb begin
    st_nxt = st;
    da     = 8'd0;
    db     = 8'd0;
    unique case (st.phase)
      PH_CREEP: begin
        st_nxt.phase_timer = timer_sat;
        if (timer_sat >= CREEP_MS) begin
          st_nxt.phase            = PH_LEFT;
          st_nxt.turn_sum         = 16'd0;
          st_nxt.return_to_decide = 1'b1;
          st_nxt.dir_a            = 1'b1;
          st_nxt.dir_b            = 1'b1;
        end else begin
          st_nxt.dir_a = 1'b1;
          st_nxt.dir_b = 1'b0;
        end
        da = TURN_DUTY;
        db = TURN_DUTY;
      end
      PH_LEFT, PH_RIGHT: begin
        st_nxt.turn_sum = turn_sat;
        if (turn_sat >= cfg.turn_tick_target) begin
          if (st.return_to_decide) begin
            st_nxt.phase = PH_DECIDE;
          end else begin
            st_nxt.phase = PH_FORWARD;
            st_nxt.dir_a = 1'b1;
            st_nxt.dir_b = 1'b0;
          end
          st_nxt.return_to_decide = 1'b0;
        end else begin
          da = TURN_DUTY;
          db = TURN_DUTY;
        end
      end
      PH_DECIDE: begin
        priority if (left_open) begin
          st_nxt.phase            = PH_LEFT;
          st_nxt.turn_sum         = 16'd0;
          st_nxt.return_to_decide = 1'b0;
          st_nxt.dir_a            = 1'b1;
          st_nxt.dir_b            = 1'b1;
          da = TURN_DUTY;
          db = TURN_DUTY;
        end else if (item.dist_center > cfg.front_block_dist) begin
          st_nxt.phase = PH_FORWARD;
          st_nxt.dir_a = 1'b1;
          st_nxt.dir_b = 1'b0;
        end else if (right_open) begin
          st_nxt.phase            = PH_RIGHT;
          st_nxt.turn_sum         = 16'd0;
          st_nxt.return_to_decide = 1'b0;
          st_nxt.dir_a            = 1'b0;
          st_nxt.dir_b            = 1'b0;
          da = TURN_DUTY;
          db = TURN_DUTY;
        end else begin
          st_nxt.phase       = PH_BACK;
          st_nxt.phase_timer = 16'd0;
          st_nxt.dir_a       = 1'b0;
          st_nxt.dir_b       = 1'b1;
          da = BACK_DUTY;
          db = BACK_DUTY;
        end
      end
      PH_PAUSE: begin
        st_nxt.phase_timer = timer_sat;
        if (timer_sat >= PAUSE_MS) begin
          st_nxt.phase            = st.pending_right_turn ? PH_RIGHT : PH_LEFT;
          st_nxt.turn_sum         = 16'd0;
          st_nxt.return_to_decide = 1'b0;
          st_nxt.dir_a            = ~st.pending_right_turn;
          st_nxt.dir_b            = ~st.pending_right_turn;
          da = TURN_DUTY;
          db = TURN_DUTY;
        end
      end
      PH_BACK: begin
        st_nxt.phase_timer = timer_sat;
        priority if (left_open || right_open) begin
          st_nxt.phase              = PH_PAUSE;
          st_nxt.phase_timer        = 16'd0;
          st_nxt.pending_right_turn = ~left_open;
        end else if (timer_sat > cfg.backward_timeout_ms) begin
          st_nxt.phase = PH_FORWARD;
          st_nxt.dir_a = 1'b1;
          st_nxt.dir_b = 1'b0;
        end else begin
          st_nxt.dir_a = 1'b0;
          st_nxt.dir_b = 1'b1;
          da = BACK_DUTY;
          db = BACK_DUTY;
        end
      end
      default: begin
        st_nxt.phase = PH_FORWARD;
        st_nxt.dir_a = 1'b1;
        st_nxt.dir_b = 1'b0;
        priority if (left_open) begin
          st_nxt.phase       = PH_CREEP;
          st_nxt.phase_timer = 16'd0;
          da = TURN_DUTY;
          db = TURN_DUTY;
        end else if (item.dist_center < cfg.front_block_dist) begin
          st_nxt.phase = PH_DECIDE;
        end else begin
          da = (sum_a < DUTY_MIN) ? DUTY_MIN[7:0] :
               (sum_a > DUTY_MAX) ? DUTY_MAX[7:0] : sum_a[7:0];
          db = (sum_b < DUTY_MIN) ? DUTY_MIN[7:0] :
               (sum_b > DUTY_MAX) ? DUTY_MAX[7:0] : sum_b[7:0];
        end
      end
    endcase
  end

  assign res.pwm_a      = da;
  assign res.pwm_b      = db;
  assign res.a_in1_high = st_nxt.dir_a;
  assign res.b_in1_high = st_nxt.dir_b;
  assign res.phase_code = st_nxt.phase;

endmodule

@@ rtl/wall_follow_maze_motion_controller_core.sv @@
// Top level of the wall-follow maze motion controller.
`timescale 1ns / 1ps
// Usage:
//   in_ch carries one control period per transfer: three range readings in mm,
//   two signed encoder deltas and the elapsed milliseconds. out_ch returns one
//   result per input transfer: both PWM duties, both direction pins and the
//   phase code after the period. cfg_we/cfg_index/cfg_data write one of eight
//   registers per clock; write them only while the block is idle.
// Datapath: an input transfer lands in the input register; the result is
//   computed combinationally from it and the phase state and loaded into the
//   output register once out_ch is free.
// Throughput: one item per cycle while out_ch is free; the phase state updates
//   in the same cycle the item moves from the input to the output register.
// Reset (rst_n low, synchronous): both registers empty, phase forward, timers
//   and flags cleared, directions forward, registers at their reset values.
// Stall: a held result keeps out_ch.valid and its payload; the input register
//   still takes one more if empty, then in_ch.ready drops until out_ch moves.
module wall_follow_maze_motion_controller_core import wfmc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  wfmc_in_if.sink             in_ch,
  wfmc_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t      cfg_r;
  state_t    st_r;
  state_t    st_nxt;
  in_item_t  in_data_r;
  logic      in_valid_r;
  out_item_t out_data_r;
  out_item_t res_nxt;
  logic      out_valid_r;
  logic      out_free;
  logic      adv;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign adv         = in_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || out_free;

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  wfmc_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (in_data_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_speed           <= 8'd170;
      cfg_r.front_block_dist     <= 16'd60;
      cfg_r.left_near_dist       <= 16'd35;
      cfg_r.right_near_dist      <= 16'd60;
      cfg_r.left_open_threshold  <= 16'd80;
      cfg_r.right_open_threshold <= 16'd80;
      cfg_r.turn_tick_target     <= 16'd10;
      cfg_r.backward_timeout_ms  <= 16'd4000;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BASE_SPEED:   cfg_r.base_speed           <= cfg_data[7:0];
        REG_CENTER_STOP:  cfg_r.front_block_dist     <= cfg_data;
        REG_LEFT_WALL:    cfg_r.left_near_dist       <= cfg_data;
        REG_RIGHT_WALL:   cfg_r.right_near_dist      <= cfg_data;
        REG_LEFT_OPEN:    cfg_r.left_open_threshold  <= cfg_data;
        REG_RIGHT_OPEN:   cfg_r.right_open_threshold <= cfg_data;
        REG_TURN_TICKS:   cfg_r.turn_tick_target     <= cfg_data;
        REG_BACK_TIMEOUT: cfg_r.backward_timeout_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r.phase              <= PH_FORWARD;
      st_r.phase_timer        <= 16'd0;
      st_r.turn_sum           <= 16'd0;
      st_r.return_to_decide   <= 1'b0;
      st_r.pending_right_turn <= 1'b0;
      st_r.dir_a              <= 1'b1;
      st_r.dir_b              <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_data_r <= in_ch.data;
    end
    if (adv) begin
      out_data_r <= res_nxt;
    end
  end

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced item did not reach output register");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !out_free) |-> !in_ch.ready)
    else $error("input taken while input register full and output stalled");

  a_back_dirs: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_BACK || st_r.phase == PH_PAUSE) |-> (!st_r.dir_a && st_r.dir_b))
    else $error("backward or pause phase without reverse directions");

  a_fwd_dirs: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_FORWARD || st_r.phase == PH_CREEP) |-> (st_r.dir_a && !st_r.dir_b))
    else $error("forward or creep phase without forward directions");

endmodule

@@ dv/tb_wall_follow_maze_motion_controller_core.sv @@
// Self-checking testbench for the wall-follow maze motion controller core.
`timescale 1ns / 1ps
module tb_wall_follow_maze_motion_controller_core;
  import wfmc_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int WallBoost   = 55;
  localparam int DutyFloor   = 120;
  localparam int DutyCeil    = 255;
  localparam int TurnDuty    = 170;
  localparam int ReverseDuty = 160;
  localparam int CreepSpanMs = 300;
  localparam int PauseSpanMs = 200;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  wfmc_in_if  in_ch ();
  wfmc_out_if out_ch ();

  wall_follow_maze_motion_controller_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // predicted controller state and register file
  cfg_t        ctl;
  phase_t      ph;
  logic [15:0] ph_timer;
  logic [15:0] turn_sum;
  logic        ret_decide;
  logic        pend_right;
  logic        dir_a;
  logic        dir_b;

  out_item_t drive_q[$];
  int        mismatch_cnt = 0;
  int        cycle_cnt = 0;
  int        burst_left = 0;
  logic [8:0] stall_cnt = '0;

  function automatic cfg_t default_config();
    cfg_t c;
    c.base_speed           = 8'd170;
    c.front_block_dist     = 16'd60;
    c.left_near_dist       = 16'd35;
    c.right_near_dist      = 16'd60;
    c.left_open_threshold  = 16'd80;
    c.right_open_threshold = 16'd80;
    c.turn_tick_target     = 16'd10;
    c.backward_timeout_ms  = 16'd4000;
    return c;
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.base_speed           = 8'($urandom);
    c.front_block_dist     = 16'($urandom_range(200));
    c.left_near_dist       = 16'($urandom_range(200));
    c.right_near_dist      = 16'($urandom_range(200));
    c.left_open_threshold  = 16'($urandom_range(200));
    c.right_open_threshold = 16'($urandom_range(200));
    c.turn_tick_target     = 16'($urandom_range(600));
    c.backward_timeout_ms  = 16'($urandom_range(3000));
    return c;
  endfunction

  function automatic logic [15:0] add_clip(logic [15:0] acc, int inc);
    int t;
    t = int'(acc) + inc;
    return (t > 65535) ? 16'hFFFF : 16'(t);
  endfunction

  function automatic int clamp_duty(int v);
    return (v < DutyFloor) ? DutyFloor : ((v > DutyCeil) ? DutyCeil : v);
  endfunction

  function automatic void begin_turn(logic right, logic ret);
    ph         = right ? PH_RIGHT : PH_LEFT;
    turn_sum   = '0;
    ret_decide = ret;
    dir_a      = !right;
    dir_b      = !right;
  endfunction

  function automatic out_item_t predict_drive(in_item_t s);
    out_item_t o;
    int le, re, ticks, a_duty, b_duty;
    logic l_open, r_open;
    le = s.enc_left_delta;
    re = s.enc_right_delta;
    ticks = ((le < 0) ? -le : le) + ((re < 0) ? -re : re);
    l_open = s.dist_left > ctl.left_open_threshold;
    r_open = s.dist_right > ctl.right_open_threshold;
    a_duty = 0;
    b_duty = 0;
    case (ph)
      PH_CREEP: begin
        ph_timer = add_clip(ph_timer, s.elapsed_ms);
        if (ph_timer >= CreepSpanMs) begin
          begin_turn(1'b0, 1'b1);
        end else begin
          dir_a = 1'b1;
          dir_b = 1'b0;
        end
        a_duty = TurnDuty;
        b_duty = TurnDuty;
      end
      PH_LEFT, PH_RIGHT: begin
        turn_sum = add_clip(turn_sum, ticks);
        if (turn_sum >= ctl.turn_tick_target) begin
          if (ret_decide) begin
            ph = PH_DECIDE;
          end else begin
            ph = PH_FORWARD;
            dir_a = 1'b1;
            dir_b = 1'b0;
          end
          ret_decide = 1'b0;
        end else begin
          a_duty = TurnDuty;
          b_duty = TurnDuty;
        end
      end
      PH_DECIDE: begin
        if (l_open) begin
          begin_turn(1'b0, 1'b0);
          a_duty = TurnDuty;
        end else if (s.dist_center > ctl.front_block_dist) begin
          ph = PH_FORWARD;
          dir_a = 1'b1;
          dir_b = 1'b0;
        end else if (r_open) begin
          begin_turn(1'b1, 1'b0);
          a_duty = TurnDuty;
        end else begin
          ph = PH_BACK;
          ph_timer = '0;
          dir_a = 1'b0;
          dir_b = 1'b1;
          a_duty = ReverseDuty;
        end
        b_duty = a_duty;
      end
      PH_PAUSE: begin
        ph_timer = add_clip(ph_timer, s.elapsed_ms);
        if (ph_timer >= PauseSpanMs) begin
          begin_turn(pend_right, 1'b0);
          a_duty = TurnDuty;
          b_duty = TurnDuty;
        end
      end
      PH_BACK: begin
        ph_timer = add_clip(ph_timer, s.elapsed_ms);
        if (l_open || r_open) begin
          ph = PH_PAUSE;
          ph_timer = '0;
          pend_right = !l_open;
        end else if (ph_timer > ctl.backward_timeout_ms) begin
          ph = PH_FORWARD;
          dir_a = 1'b1;
          dir_b = 1'b0;
        end else begin
          dir_a = 1'b0;
          dir_b = 1'b1;
          a_duty = ReverseDuty;
          b_duty = ReverseDuty;
        end
      end
      default: begin
        ph = PH_FORWARD;
        dir_a = 1'b1;
        dir_b = 1'b0;
        if (l_open) begin
          ph = PH_CREEP;
          ph_timer = '0;
          a_duty = TurnDuty;
          b_duty = TurnDuty;
        end else if (s.dist_center < ctl.front_block_dist) begin
          ph = PH_DECIDE;
        end else begin
          a_duty = int'(ctl.base_speed);
          b_duty = int'(ctl.base_speed);
          if (s.dist_left < ctl.left_near_dist) b_duty += WallBoost;
          if (s.dist_right < ctl.right_near_dist) a_duty += WallBoost;
          a_duty = clamp_duty(a_duty);
          b_duty = clamp_duty(b_duty);
        end
      end
    endcase
    o.pwm_a      = 8'(a_duty);
    o.pwm_b      = 8'(b_duty);
    o.a_in1_high = dir_a;
    o.b_in1_high = dir_b;
    o.phase_code = ph;
    return o;
  endfunction

  function automatic in_item_t pkt(int r, int c, int l, int el, int er, int ms);
    in_item_t s;
    s.dist_right      = 16'(r);
    s.dist_center     = 16'(c);
    s.dist_left       = 16'(l);
    s.enc_left_delta  = 8'(el);
    s.enc_right_delta = 8'(er);
    s.elapsed_ms      = 8'(ms);
    return s;
  endfunction

  function automatic logic [15:0] dist_below(int lim);
    if (lim <= 0) return 16'd0;
    if ($urandom_range(1) == 0) return 16'($urandom_range(lim - 1, 0));
    return 16'($urandom_range(lim - 1, (lim > 150) ? lim - 150 : 0));
  endfunction

  function automatic logic [15:0] dist_above(int lim);
    int hi;
    if (lim >= 65535) return 16'hFFFF;
    hi = (lim + 150 > 65535) ? 65535 : lim + 150;
    if ($urandom_range(1) == 0) return 16'($urandom_range(65535, lim + 1));
    return 16'($urandom_range(hi, lim + 1));
  endfunction

  function automatic logic [15:0] dist_near(int t);
    return 16'($urandom_range((t + 3 > 65535) ? 65535 : t + 3, (t > 3) ? t - 3 : 0));
  endfunction

  function automatic logic [15:0] any_dist();
    case ($urandom_range(3))
      0, 1: return 16'($urandom_range(200));
      2: return 16'($urandom);
      default: return 16'($urandom_range(2000));
    endcase
  endfunction

  function automatic logic [7:0] any_ticks();
    if ($urandom_range(1) == 0) return 8'($urandom);
    return 8'(int'($urandom_range(16)) - 8);
  endfunction

  // steer distances toward the decisions of the predicted phase
  function automatic in_item_t gen_sample();
    in_item_t s;
    int pick, lopen, ropen, stop;
    s.dist_right      = any_dist();
    s.dist_center     = any_dist();
    s.dist_left       = any_dist();
    s.enc_left_delta  = any_ticks();
    s.enc_right_delta = any_ticks();
    s.elapsed_ms      = 8'($urandom_range(255));
    lopen = ctl.left_open_threshold;
    ropen = ctl.right_open_threshold;
    stop  = ctl.front_block_dist;
    pick  = $urandom_range(99);
    if (pick < 10) return s;
    case (ph)
      PH_DECIDE: begin
        s.dist_left   = (pick < 30) ? dist_above(lopen) : dist_below(lopen + 1);
        s.dist_center = (pick >= 30 && pick < 55) ? dist_above(stop) : dist_below(stop + 1);
        s.dist_right  = (pick >= 55 && pick < 80) ? dist_above(ropen) : dist_below(ropen + 1);
      end
      PH_BACK: begin
        s.dist_left  = (pick < 20) ? dist_above(lopen) : dist_below(lopen + 1);
        s.dist_right = (pick >= 20 && pick < 35) ? dist_above(ropen) : dist_below(ropen + 1);
      end
      PH_FORWARD: begin
        if (pick < 20) s.dist_left = dist_above(lopen);
        else if (pick < 60) s.dist_left = dist_near(ctl.left_near_dist);
        else s.dist_left = dist_below(lopen + 1);
        s.dist_center = (pick >= 20 && pick < 35) ? dist_below(stop) : dist_above(stop - 1);
        s.dist_right  = (pick % 2 == 0) ? dist_near(ctl.right_near_dist) : any_dist();
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic send_sample(input in_item_t s);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(80, 40) : $urandom_range(12, 1);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data  <= s;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    drive_q.push_back(predict_drive(s));
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic put_reg(input reg_idx_t idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    wait_idle();
    cfg_we <= 1'b1;
    put_reg(REG_BASE_SPEED, {8'($urandom), c.base_speed});
    put_reg(REG_CENTER_STOP, c.front_block_dist);
    put_reg(REG_LEFT_WALL, c.left_near_dist);
    put_reg(REG_RIGHT_WALL, c.right_near_dist);
    put_reg(REG_LEFT_OPEN, c.left_open_threshold);
    put_reg(REG_RIGHT_OPEN, c.right_open_threshold);
    put_reg(REG_TURN_TICKS, c.turn_tick_target);
    put_reg(REG_BACK_TIMEOUT, c.backward_timeout_ms);
    cfg_we <= 1'b0;
    ctl = c;
  endtask

  task automatic test_reset_defaults();
    send_sample(pkt(100, 500, 50, 0, 0, 0));
    send_sample(pkt(0, 65535, 0, 0, 0, 255));
    send_sample(pkt(0, 65535, 65535, 0, 0, 0));
    send_sample(pkt(0, 0, 0, 0, 0, 255));
    send_sample(pkt(0, 0, 0, 0, 0, 255));
    send_sample(pkt(0, 0, 0, -128, 127, 0));
    send_sample(pkt(0, 0, 0, 0, 0, 0));
    send_sample(pkt(0, 0, 0, 0, 0, 255));
    send_sample(pkt(65535, 0, 0, 0, 0, 0));
    send_sample(pkt(0, 0, 0, 0, 0, 255));
    send_sample(pkt(0, 0, 0, 0, 0, 0));
    send_sample(pkt(0, 100, 0, 5, 5, 0));
    send_sample(pkt(0, 0, 0, 0, 0, 0));
    send_sample(pkt(0, 65535, 0, 0, 0, 0));
    send_sample(pkt(0, 0, 0, 0, 0, 0));
    send_sample(pkt(0, 0, 65535, 0, 0, 0));
    send_sample(pkt(0, 0, 0, 127, 127, 0));
  endtask

  task automatic test_turn_saturation();
    cfg_t cfg;
    cfg = default_config();
    cfg.turn_tick_target    = 16'hFFFF;
    cfg.backward_timeout_ms = 16'hFFFF;
    load_config(cfg);
    send_sample(pkt(0, 1000, 1000, 0, 0, 0));
    send_sample(pkt(0, 0, 0, 0, 0, 255));
    send_sample(pkt(0, 0, 0, 0, 0, 255));
    repeat (256) send_sample(pkt(0, 0, 0, -128, -128, 0));
    send_sample(pkt(0, 65535, 0, 0, 0, 0));
  endtask

  task automatic test_register_extremes();
    cfg_t cfg;
    cfg = '0;
    load_config(cfg);
    send_sample(pkt(0, 0, 0, 0, 0, 0));
    send_sample(pkt(0, 0, 5, 0, 0, 0));
    send_sample(pkt(0, 0, 0, 0, 0, 255));
    send_sample(pkt(0, 0, 0, 0, 0, 255));
    send_sample(pkt(0, 0, 0, 0, 0, 0));
    send_sample(pkt(0, 0, 0, 0, 0, 0));
    send_sample(pkt(0, 0, 0, 0, 0, 1));
    cfg = '1;
    load_config(cfg);
    send_sample(pkt(0, 65535, 0, 0, 0, 0));
    send_sample(pkt(0, 0, 0, 0, 0, 0));
    send_sample(pkt(65535, 0, 65535, 0, 0, 0));
  endtask

  task automatic test_random_traffic();
    cfg_t cfg;
    for (int k = 0; k < 4; k++) begin
      cfg = (k == 0) ? default_config() : random_config();
      load_config(cfg);
      repeat (170) send_sample(gen_sample());
    end
  endtask

  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 9'd1;
    case (stall_cnt[8:7])
      2'd0: out_ch.ready <= 1'b1;
      2'd1: out_ch.ready <= ($urandom_range(3) != 0);
      2'd2: out_ch.ready <= (stall_cnt[2:0] != 3'd5) && (stall_cnt[4:3] != 2'd2);
      default: out_ch.ready <= ($urandom_range(3) == 0);
    endcase
  end

  always @(posedge clk) begin
    out_item_t want, got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = out_ch.data;
      if (drive_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: transfer with nothing pending: pwm %0d/%0d dir %b%b phase %0d",
                   $realtime, got.pwm_a, got.pwm_b, got.a_in1_high, got.b_in1_high,
                   got.phase_code);
      end else begin
        want = drive_q.pop_front();
        if (got.pwm_a !== want.pwm_a || got.pwm_b !== want.pwm_b ||
            got.a_in1_high !== want.a_in1_high || got.b_in1_high !== want.b_in1_high ||
            got.phase_code !== want.phase_code) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: exp pwm %0d/%0d dir %b%b phase %0d, got pwm %0d/%0d dir %b%b phase %0d",
                     $realtime, want.pwm_a, want.pwm_b, want.a_in1_high, want.b_in1_high,
                     want.phase_code, got.pwm_a, got.pwm_b, got.a_in1_high,
                     got.b_in1_high, got.phase_code);
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    ctl        = default_config();
    ph         = PH_FORWARD;
    ph_timer   = '0;
    turn_sum   = '0;
    ret_decide = 1'b0;
    pend_right = 1'b0;
    dir_a      = 1'b1;
    dir_b      = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_turn_saturation();
    test_register_extremes();
    test_random_traffic();
    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
